FILE: rtl/chc_pkg.sv
// shared types and constants for the chained hash occurrence counter
package chc_pkg;
    localparam int KEY_W = 31;
    localparam int CNT_W = 31;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;
endpackage

FILE: rtl/chained_hash_occurrence_counter_unit.sv
// top level of the chained hash occurrence counter
// Counts key occurrences in a separate-chaining hash table.
// Slave channel: one request item per handshake, tdata holds key (bits 30:0),
//   tuser the request kind (0 insert, 1 query).
// Master channel: one result item per request, tdata holds occurrences
//   (bits 30:0) and status (bit 31, 1 when the node pool is full).
// The front end reduces the key modulo BUCKET_COUNT by a reciprocal multiply,
// a low-bit subtract and one correcting subtract, then queues the item (two
// entries); it takes a new item only once the last one is queued.
// The back end takes an item from the queue and reads the bucket head, then
// reads the chain nodes one after another until the key is found or the
// chain ends. The chain walk bounds throughput, the modulo of the next item
// overlaps it.
// After reset the back end clears the bucket heads, one per cycle, and
// takes no item meanwhile.
// A stalled receiver holds the result; the back end waits with the next
// one, the queue then fills and the slave side deasserts tready.
module chained_hash_occurrence_counter_unit #(
    parameter int BUCKET_COUNT = 1009,
    parameter int NODE_POOL = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // key [30:0], zero pad [31]
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // occurrences [30:0], status [31]
);
    import chc_pkg::*;

    localparam int BKT_W = $clog2(BUCKET_COUNT);
    localparam int LNK_W = $clog2(NODE_POOL + 1);

    logic             q_valid, q_ready, q_req;
    logic [KEY_W-1:0] q_key;
    logic [BKT_W-1:0] q_bkt;
    logic [CNT_W-1:0] occ;
    logic             st;

    // front end
    chc_front #(.BUCKET_COUNT(BUCKET_COUNT), .BKT_W(BKT_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req(s_axis_tuser), .i_key(s_axis_tdata[KEY_W-1:0]),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_req(q_req), .o_key(q_key), .o_bucket(q_bkt)
    );

    // back end
    chc_back #(.BUCKET_COUNT(BUCKET_COUNT), .NODE_POOL(NODE_POOL),
               .BKT_W(BKT_W), .LNK_W(LNK_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_req(q_req), .i_key(q_key), .i_bucket(q_bkt),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_occ(occ), .o_status(st)
    );

    assign m_axis_tdata = {st, occ};
endmodule

FILE: rtl/chc_front.sv
// front end: accepts request items, reduces the key to a bucket and queues them
module chc_front #(
    parameter int BUCKET_COUNT = 1009,
    parameter int BKT_W = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req,
    input  logic [chc_pkg::KEY_W-1:0] i_key,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_req,
    output logic [chc_pkg::KEY_W-1:0] o_key,
    output logic [BKT_W-1:0]          o_bucket
);
    import chc_pkg::*;

    // remainder before the last correction stays below twice the bucket count
    localparam int RW = BKT_W + 1;
    localparam int PW = KEY_W + 32;
    // reciprocal of the bucket count scaled by 2^32, rounded down
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKET_COUNT));
    localparam logic [1:0] P_MUL = 2'd0, P_SUB = 2'd1, P_FIN = 2'd2;

    // modulo unit: reciprocal multiply, low-bit subtract, one correction
    logic             r_busy, n_busy;
    logic [1:0]       r_phase, n_phase;
    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_quot;
    logic [RW-1:0]    r_rem;

    // two entry queue towards the back end
    logic [1:0]           r_qv;
    logic [KEY_W+BKT_W:0] r_q [2];
    logic                 accept, push, pop;
    logic [PW-1:0]        prod;
    logic [RW-1:0]        fin;
    logic [KEY_W+BKT_W:0] item;

    assign o_ready = !r_busy;
    assign accept  = i_valid && !r_busy;
    assign push    = r_busy && r_phase == P_FIN && !r_qv[1];
    assign prod    = PW'(r_key) * PW'(RECIP);
    assign fin     = (r_rem >= RW'(BUCKET_COUNT)) ? r_rem - RW'(BUCKET_COUNT) : r_rem;
    assign item    = {r_req, r_key, fin[BKT_W-1:0]};

    // phase sequencing, the last phase holds while the queue is full
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        case (r_phase)
            P_MUL: if (r_busy) n_phase = P_SUB;
            P_SUB: n_phase = P_FIN;
            P_FIN: if (push) begin
                n_busy  = 1'b0;
                n_phase = P_MUL;
            end
            default: n_phase = P_MUL;
        endcase
        if (accept) n_busy = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= P_MUL;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
        end
        if (accept) begin
            r_req <= i_req;
            r_key <= i_key;
        end
        // estimated quotient is exact or one short
        if (r_busy && r_phase == P_MUL)
            r_quot <= prod[PW-1:32];
        if (r_phase == P_SUB)
            r_rem <= RW'(r_key) - RW'(r_quot) * RW'(BUCKET_COUNT);
    end

    // queue bookkeeping
    assign pop     = r_qv[0] && i_ready;
    assign o_valid = r_qv[0];
    assign o_req   = r_q[0][KEY_W+BKT_W];
    assign o_key   = r_q[0][KEY_W+BKT_W-1:BKT_W];
    assign o_bucket = r_q[0][BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else begin
            case ({push, pop})
                2'b10: r_qv <= {r_qv[0], 1'b1};
                2'b01: r_qv <= {1'b0, r_qv[1]};
                default: r_qv <= r_qv;
            endcase
        end
        if (push && r_qv[0] && !pop)
            r_q[1] <= item;
        if (push && (!r_qv[0] || pop))
            r_q[0] <= item;
        else if (pop)
            r_q[0] <= r_q[1];
    end
endmodule

FILE: rtl/chc_back.sv
// back end: walks bucket chains in memory, updates node counts and inserts new nodes
module chc_back #(
    parameter int BUCKET_COUNT = 1009,
    parameter int NODE_POOL = 1024,
    parameter int BKT_W = 10,
    parameter int LNK_W = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req,
    input  logic [chc_pkg::KEY_W-1:0] i_key,
    input  logic [BKT_W-1:0]          i_bucket,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [chc_pkg::CNT_W-1:0] o_occ,
    output logic                      o_status
);
    import chc_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2,
        S_HWAIT = 4'd3, S_NODE = 4'd4, S_NWAIT = 4'd5, S_CHECK = 4'd6;
    localparam int IDX_W = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;

    logic [LNK_W-1:0] bucket_mem [BUCKET_COUNT];
    logic [KEY_W-1:0] key_mem    [NODE_POOL];
    logic [CNT_W-1:0] cnt_mem    [NODE_POOL];
    logic [LNK_W-1:0] next_mem   [NODE_POOL];

    logic [3:0]       r_state;
    logic [BKT_W-1:0] r_clr;
    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic [BKT_W-1:0] r_bkt;
    logic [LNK_W-1:0] r_head, r_link, r_used;
    logic [KEY_W-1:0] r_nkey;
    logic [CNT_W-1:0] r_ncnt;
    logic [LNK_W-1:0] r_nnext;
    logic             r_ov;
    logic [CNT_W-1:0] r_occ;
    logic             r_st;
    logic [IDX_W-1:0] idx, nidx;
    logic             check_fire;

    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_ov;
    assign o_occ    = r_occ;
    assign o_status = r_st;
    assign idx      = IDX_W'(r_link - LNK_W'(1));
    assign nidx     = IDX_W'(r_used);
    // the update is done only once the result register is free
    assign check_fire = r_state == S_CHECK && (!r_ov || i_ready);

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_head  <= bucket_mem[r_bkt];
        r_nkey  <= key_mem[idx];
        r_ncnt  <= cnt_mem[idx];
        r_nnext <= next_mem[idx];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR)
            bucket_mem[r_clr] <= '0;
        else if (check_fire && r_req == REQ_INSERT && r_link == '0
                 && r_used != LNK_W'(NODE_POOL))
            bucket_mem[r_bkt] <= r_used + LNK_W'(1);
        if (check_fire && r_req == REQ_INSERT) begin
            if (r_link != '0 && r_ncnt != CNT_MAX)
                cnt_mem[idx] <= r_ncnt + CNT_W'(1);
            else if (r_link == '0 && r_used != LNK_W'(NODE_POOL)) begin
                key_mem[nidx]  <= r_key;
                cnt_mem[nidx]  <= CNT_W'(1);
                next_mem[nidx] <= r_head;
            end
        end
    end

    // chain walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= (r_ov && !i_ready) || check_fire;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BKT_W'(1);
                    if (r_clr == BKT_W'(BUCKET_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_req <= i_req;
                    r_key <= i_key;
                    r_bkt <= i_bucket;
                    r_state <= S_HEAD;
                end
                S_HEAD: r_state <= S_HWAIT;
                S_HWAIT: begin
                    r_link  <= r_head;
                    r_state <= S_NODE;
                end
                S_NODE: begin
                    if (r_link == '0) r_state <= S_CHECK;
                    else r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (r_nkey == r_key) r_state <= S_CHECK;
                    else begin
                        r_link  <= r_nnext;
                        r_state <= S_NODE;
                    end
                end
                S_CHECK: if (check_fire) begin
                    r_st <= STATUS_OK;
                    if (r_req == REQ_QUERY)
                        r_occ <= (r_link == '0) ? '0 : r_ncnt;
                    else if (r_link != '0)
                        r_occ <= (r_ncnt == CNT_MAX) ? r_ncnt : r_ncnt + CNT_W'(1);
                    else if (r_used == LNK_W'(NODE_POOL)) begin
                        r_occ <= '0;
                        r_st  <= STATUS_FULL;
                    end else begin
                        r_occ  <= CNT_W'(1);
                        r_used <= r_used + LNK_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/chc_checker.sv
// port level checks for the chained hash occurrence counter
module chc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // a full pool result carries a zero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30:0] == 31'd0)
        else $error("pool full with nonzero count");
    // no result right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    // an offered result is fully known
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("unknown bits in result");
endmodule

bind chained_hash_occurrence_counter_unit chc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
